@@ hdl/utt_pkg.sv @@
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 transcoder package
// Shared constants, the command type that the front end hands to the back
// end, and the helpers used to classify and order bytes.
// ----------------------------------------------------------------------------
package utt_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [1:0] MODE_PASS = 2'd0;
    localparam logic [1:0] MODE_LE   = 2'd1;
    localparam logic [1:0] MODE_BE   = 2'd2;

    localparam logic REG_OUT_MODE = 1'b0;

    localparam logic [1:0] LAST_PASS = 2'd0;
    localparam logic [1:0] LAST_UNIT = 2'd1;
    localparam logic [1:0] LAST_PAIR = 2'd3;

    typedef struct packed {
        logic [1:0]      last_idx;
        logic [3:0][7:0] bytes;
    } utt_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } utt_q_status_t;

    function automatic logic [2:0] lead_len(input logic [7:0] b);
        logic [2:0] len;
        len = 3'd0;
        if (b[7] == 1'b0) begin
            len = 3'd1;
        end else if (b[7:5] == 3'b110) begin
            len = 3'd2;
        end else if (b[7:4] == 4'b1110) begin
            len = 3'd3;
        end else if (b[7:3] == 5'b11110) begin
            len = 3'd4;
        end
        return len;
    endfunction

    function automatic logic [15:0] order_unit(input logic [15:0] unit, input logic little);
        logic [15:0] res;
        res = little ? {unit[15:8], unit[7:0]} : {unit[7:0], unit[15:8]};
        return res;
    endfunction

endpackage

@@ hdl/utf8_to_utf16_transcoder_unit.sv @@
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 transcoder
// Converts a UTF-8 byte stream to UTF-16 little- or big-endian bytes, or
// passes bytes through unchanged.
// ----------------------------------------------------------------------------
// The block takes one input byte per cycle whenever its command queue has
// room, and the result channel moves one byte per cycle while the receiver
// is ready. An ASCII byte in a UTF-16 mode yields two output bytes, so it
// occupies the output for two byte transfers, where a passthrough byte
// needs one. Lead and middle bytes of a multi-byte sequence produce nothing,
// and the final byte produces two bytes, or four for a surrogate pair. The
// byte-wide output port sets the rate; the queue of QUEUE_DEPTH commands
// lets input continue while earlier results are still being sent. Write
// out_mode at address 0 only while the block is idle.
module utf8_to_utf16_transcoder_unit #(
    parameter int QUEUE_DEPTH = utt_pkg::QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic        m_tlast
);
    import utt_pkg::*;

    logic          mode_q;
    logic [1:0]    mode;
    logic          push;
    logic          pop;
    utt_cmd_t      push_cmd;
    utt_cmd_t      head;
    utt_q_status_t q_status;

    assign mode_q = (mode == MODE_LE);

    utt_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .mode    (mode)
    );

    utt_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .mode     (mode),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_status (q_status),
        .push     (push),
        .cmd      (push_cmd)
    );

    utt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .status   (q_status)
    );

    utt_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .q_status (q_status),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    a_ascii_le_low_byte_first: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (push && mode_q && (s_tdata[7] == 1'b0)) |-> (push_cmd.bytes[1] == 8'd0))
        else $error("top: little-endian ASCII unit must send its high byte second");

endmodule

@@ hdl/utt_front.sv @@
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 transcoder front end
// Accepts input bytes, tracks the pending multi-byte sequence, assembles the
// code point and pushes an ordered byte command into the queue.
// ----------------------------------------------------------------------------
module utt_front (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [1:0]             mode,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,
    input  utt_pkg::utt_q_status_t q_status,
    output logic                   push,
    output utt_pkg::utt_cmd_t      cmd
);
    import utt_pkg::*;

    logic [1:0]  count_reg, count_next;
    logic [7:0]  seq0_reg, seq0_next;
    logic [7:0]  seq1_reg, seq1_next;
    logic [7:0]  seq2_reg, seq2_next;
    logic        accept;
    logic        utf;
    logic        little;
    logic        emit;
    logic [2:0]  len;
    logic [20:0] cp;
    logic [19:0] v;
    logic [15:0] unit_a;
    logic [15:0] unit_b;

    assign s_tready = !q_status.full;
    assign accept   = s_tvalid && s_tready;
    assign utf      = (mode == MODE_LE) || (mode == MODE_BE);
    assign little   = (mode == MODE_LE);
    assign len      = lead_len(seq0_reg);

    always_comb begin
        case (len)
            3'd2:    cp = {10'd0, seq0_reg[4:0], s_tdata[5:0]};
            3'd3:    cp = {5'd0, seq0_reg[3:0], seq1_reg[5:0], s_tdata[5:0]};
            default: cp = {seq0_reg[2:0], seq1_reg[5:0], seq2_reg[5:0], s_tdata[5:0]};
        endcase
    end

    assign v      = 20'(cp - 21'h10000);
    assign unit_a = order_unit(16'hD800 | {6'd0, v[19:10]}, little);
    assign unit_b = order_unit(16'hDC00 | {6'd0, v[9:0]}, little);

    always_comb begin
        count_next    = count_reg;
        seq0_next     = seq0_reg;
        seq1_next     = seq1_reg;
        seq2_next     = seq2_reg;
        emit          = 1'b0;
        cmd.last_idx  = LAST_PASS;
        cmd.bytes     = {24'd0, s_tdata};
        if (!utf) begin
            emit = 1'b1;
        end else if (s_tdata[7] == 1'b0) begin
            emit         = 1'b1;
            cmd.last_idx = LAST_UNIT;
            cmd.bytes    = {16'd0, order_unit({8'd0, s_tdata}, little)};
        end else if (count_reg == 2'd0) begin
            if (lead_len(s_tdata) >= 3'd2) begin
                seq0_next  = s_tdata;
                count_next = 2'd1;
            end
        end else if ({1'b0, count_reg} + 3'd1 < len) begin
            count_next = count_reg + 2'd1;
            if (count_reg == 2'd1) begin
                seq1_next = s_tdata;
            end else begin
                seq2_next = s_tdata;
            end
        end else begin
            emit       = 1'b1;
            count_next = 2'd0;
            if (cp[20:16] == 5'd0) begin
                cmd.last_idx = LAST_UNIT;
                cmd.bytes    = {16'd0, order_unit(cp[15:0], little)};
            end else begin
                cmd.last_idx = LAST_PAIR;
                cmd.bytes    = {unit_b, unit_a};
            end
        end
    end

    assign push = accept && emit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else if (accept) begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            seq0_reg <= seq0_next;
            seq1_reg <= seq1_next;
            seq2_reg <= seq2_next;
        end
    end

    a_count_three_needs_four_byte_lead: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (count_reg == 2'd3) |-> (lead_len(seq0_reg) == 3'd4))
        else $error("front: three bytes pending without a four-byte lead");

endmodule

@@ hdl/utt_queue.sv @@
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 transcoder command queue
// A short register FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module utt_queue #(
    parameter int DEPTH = utt_pkg::QUEUE_DEPTH
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  utt_pkg::utt_cmd_t      push_cmd,
    input  logic                   pop,
    output utt_pkg::utt_cmd_t      head,
    output utt_pkg::utt_q_status_t status
);
    import utt_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    utt_cmd_t             mem [DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]     count_reg, count_next;

    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign head         = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    a_no_push_when_full: assert property (
        @(posedge aclk) disable iff (!aresetn)
        !(push && status.full))
        else $error("queue: push while full");

    a_no_pop_when_empty: assert property (
        @(posedge aclk) disable iff (!aresetn)
        !(pop && status.empty))
        else $error("queue: pop while empty");

    a_count_tracks_ops: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue: count did not follow a lone push");

endmodule

@@ hdl/utt_back.sv @@
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 transcoder back end
// Serializes the queued byte commands onto the byte-wide result channel.
// ----------------------------------------------------------------------------
module utt_back (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  utt_pkg::utt_cmd_t      head,
    input  utt_pkg::utt_q_status_t q_status,
    output logic                   pop,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [7:0]             m_tdata,
    output logic                   m_tlast
);
    import utt_pkg::*;

    logic [1:0] idx_reg, idx_next;
    logic       xfer;

    assign m_tvalid = !q_status.empty;
    assign m_tdata  = head.bytes[idx_reg];
    assign m_tlast  = (idx_reg == head.last_idx);
    assign xfer     = m_tvalid && m_tready;
    assign pop      = xfer && m_tlast;

    always_comb begin
        idx_next = idx_reg;
        if (pop) begin
            idx_next = 2'd0;
        end else if (xfer) begin
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= 2'd0;
        end else begin
            idx_reg <= idx_next;
        end
    end

    a_index_within_command: assert property (
        @(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (idx_reg <= head.last_idx))
        else $error("back: byte index ran past the command");

endmodule

@@ hdl/utt_top_note.sv @@
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 transcoder configuration register
// Holds the output mode written through the APB-style port.
// ----------------------------------------------------------------------------
module utt_cfg (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [1:0]  mode
);
    import utt_pkg::*;

    logic [1:0] mode_reg, mode_next;
    logic       wr;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite && pready;
    assign mode   = mode_reg;
    assign prdata = (paddr[2] == REG_OUT_MODE) ? {30'd0, mode_reg} : 32'd0;

    always_comb begin
        mode_next = mode_reg;
        if (wr && (paddr[2] == REG_OUT_MODE)) begin
            mode_next = pwdata[1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_PASS;
        end else begin
            mode_reg <= mode_next;
        end
    end

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 transcoder testbench
// Drives UTF-8 bytes into the block in all four mode settings and predicts
// every output byte with a scoreboard that keeps its own copy of the pending
// sequence. Each output transaction is checked in order against that
// prediction. Both stream sides idle at random, with some stretches of
// back-to-back traffic.
// ----------------------------------------------------------------------------
module testbench;
    import utt_pkg::*;

    localparam logic [1:0] MODE_RESERVED = 2'd3;
    localparam logic [2:0] OUT_MODE_ADDR = {REG_OUT_MODE, 2'b00};
    localparam int         CYCLE_LIMIT   = 300000;
    localparam int         SETTLE_CYCLES = 12;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } out_beat_t;

    class utf16_scoreboard;
        logic [1:0]  mode;
        logic [7:0]  held_bytes [3];
        int unsigned held_count;
        out_beat_t   expected_beats [$];
        int unsigned bytes_in;
        int unsigned bytes_out;
        int unsigned pairs;
        int unsigned dropped;
        int unsigned errors;

        function new();
            mode       = MODE_PASS;
            held_count = 0;
            bytes_in   = 0;
            bytes_out  = 0;
            pairs      = 0;
            dropped    = 0;
            errors     = 0;
        endfunction

        function int unsigned seq_length(logic [7:0] b);
            if (!b[7]) return 1;
            if (b[7:5] == 3'b110) return 2;
            if (b[7:4] == 4'b1110) return 3;
            if (b[7:3] == 5'b11110) return 4;
            return 0;
        endfunction

        function void expect_beat(out_beat_t beat);
            expected_beats = {expected_beats, beat};
        endfunction

        function void push_unit(logic [15:0] unit, logic last);
            out_beat_t first_beat;
            out_beat_t second_beat;
            first_beat.data  = (mode == MODE_LE) ? unit[7:0] : unit[15:8];
            first_beat.last  = 1'b0;
            second_beat.data = (mode == MODE_LE) ? unit[15:8] : unit[7:0];
            second_beat.last = last;
            expect_beat(first_beat);
            expect_beat(second_beat);
        endfunction

        function void accept_byte(logic [7:0] b);
            out_beat_t   beat;
            logic [31:0] seq [4];
            logic [31:0] code_point;
            logic [19:0] offset;
            int unsigned len;
            bytes_in++;
            if (mode != MODE_LE && mode != MODE_BE) begin
                beat.data = b;
                beat.last = 1'b1;
                expect_beat(beat);
                return;
            end
            if (!b[7]) begin
                push_unit({8'h00, b}, 1'b1);
                return;
            end
            if (held_count == 0) begin
                if (seq_length(b) < 2) begin
                    dropped++;
                end else begin
                    held_bytes[0] = b;
                    held_count    = 1;
                end
                return;
            end
            len = seq_length(held_bytes[0]);
            if (held_count + 1 < len) begin
                held_bytes[held_count] = b;
                held_count++;
                return;
            end
            for (int i = 0; i < 4; i++) begin
                seq[i] = (i < held_count) ? {24'd0, held_bytes[i]} : 32'd0;
            end
            seq[held_count] = {24'd0, b};
            held_count = 0;
            if (len == 2) begin
                code_point = ((seq[0] << 6) & 32'h7ff) + (seq[1] & 32'h3f);
            end else if (len == 3) begin
                code_point = ((seq[0] << 12) & 32'hffff) + ((seq[1] << 6) & 32'hfff)
                           + (seq[2] & 32'h3f);
            end else begin
                code_point = ((seq[0] << 18) & 32'h1fffff) + ((seq[1] << 12) & 32'h3ffff)
                           + ((seq[2] << 6) & 32'hfff) + (seq[3] & 32'h3f);
            end
            if (code_point < 32'h10000) begin
                push_unit(code_point[15:0], 1'b1);
            end else begin
                offset = 20'(code_point - 32'h10000);
                push_unit({6'b110110, offset[19:10]}, 1'b0);
                push_unit({6'b110111, offset[9:0]}, 1'b1);
                pairs++;
            end
        endfunction

        function void check_byte(logic [7:0] data, logic last);
            out_beat_t beat;
            bytes_out++;
            if (expected_beats.size() == 0) begin
                $error("unexpected output transaction: out_byte 0x%02h last_of_run %0b",
                       data, last);
                errors++;
                return;
            end
            beat = expected_beats.pop_front();
            if (data !== beat.data) begin
                $error("out_byte: expected 0x%02h, actual 0x%02h", beat.data, data);
                errors++;
            end
            if (last !== beat.last) begin
                $error("last_of_run: expected %0b, actual %0b", beat.last, last);
                errors++;
            end
        endfunction

        function int unsigned pending();
            return expected_beats.size();
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] in_byte
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // [7:0] out_byte
    logic        m_tlast;

    utf16_scoreboard transcoder_sb;
    int unsigned     in_gap_max;
    int unsigned     out_gap_max;
    int unsigned     cycle_count = 0;

    utf8_to_utf16_transcoder_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic send_byte(logic [7:0] b);
        int unsigned gap;
        gap = $urandom_range(0, in_gap_max);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        transcoder_sb.accept_byte(b);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (transcoder_sb.pending() > 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_mode(logic [1:0] mode);
        wait_drained();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= OUT_MODE_ADDR;
        pwdata  <= {30'd0, mode};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        transcoder_sb.mode = mode;
    endtask

    function automatic logic [7:0] random_continuation();
        if ($urandom_range(0, 7) == 0) return 8'($urandom_range(8'h80, 8'hff));
        return {2'b10, 6'($urandom)};
    endfunction

    task automatic send_sequence(int unsigned len);
        logic [7:0] lead;
        case (len)
            2: lead = {3'b110, 5'($urandom)};
            3: lead = {4'b1110, 4'($urandom)};
            default: lead = {5'b11110, 3'($urandom)};
        endcase
        send_byte(lead);
        for (int i = 1; i < len; i++) begin
            send_byte(random_continuation());
        end
    endtask

    task automatic send_random_traffic(int unsigned count);
        int unsigned start;
        int unsigned pick;
        start = transcoder_sb.bytes_in;
        while (transcoder_sb.bytes_in - start < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 25) begin
                send_byte(8'($urandom_range(0, 127)));
            end else if (pick < 45) begin
                send_sequence(2);
            end else if (pick < 65) begin
                send_sequence(3);
            end else if (pick < 80) begin
                send_sequence(4);
            end else if (pick < 87) begin
                send_byte({4'b1110, 4'($urandom)});
                send_byte(8'($urandom_range(0, 127)));
                send_byte(random_continuation());
                send_byte(random_continuation());
            end else if (pick < 94) begin
                send_byte(8'($urandom_range(8'h80, 8'hff)));
            end else begin
                send_byte({5'b11110, 3'($urandom)});
                send_sequence($urandom_range(2, 4));
            end
        end
    endtask

    task automatic send_list(logic [7:0] list [$]);
        foreach (list[i]) send_byte(list[i]);
    endtask

    initial begin
        int unsigned gap;
        forever begin
            gap = $urandom_range(0, out_gap_max);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (aresetn !== 1'b1 || m_tvalid !== 1'b1);
            transcoder_sb.check_byte(m_tdata, m_tlast);
        end
    end

    initial begin
        logic [1:0] phase_modes [6];
        transcoder_sb = new();
        in_gap_max    = 0;
        out_gap_max   = 0;
        aresetn  <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Back-to-back traffic first, then random idling on both sides.
        write_mode(MODE_LE);
        send_list('{8'h00, 8'h7f, 8'hc2, 8'ha9, 8'he2, 8'h82, 8'hac,
                    8'hf0, 8'h9f, 8'h98, 8'h80, 8'hf7, 8'hbf, 8'hbf, 8'hbf});
        in_gap_max  = 10;
        out_gap_max = 10;
        send_list('{8'h80, 8'hff, 8'hf8, 8'he2, 8'h41, 8'h82, 8'hac,
                    8'hc0, 8'h80, 8'hed, 8'ha0, 8'h80});
        write_mode(MODE_BE);
        send_list('{8'hf4, 8'h90, 8'h80, 8'h80, 8'h7f, 8'hc3, 8'h80, 8'hf0, 8'h9f});

        // A pending sequence survives a stretch of passthrough and resumes.
        write_mode(MODE_PASS);
        send_list('{8'h80, 8'hff, 8'h41});
        write_mode(MODE_BE);
        send_list('{8'h98, 8'h80});
        write_mode(MODE_RESERVED);
        send_list('{8'hc3, 8'h00});

        phase_modes = '{MODE_LE, MODE_BE, MODE_PASS, MODE_RESERVED, MODE_BE, MODE_LE};
        foreach (phase_modes[p]) begin
            write_mode(phase_modes[p]);
            in_gap_max  = (p % 3 == 1) ? 0 : 10;
            out_gap_max = (p % 3 == 2) ? 0 : 10;
            send_random_traffic(10);
            if (p == 1) wait_drained();
            send_random_traffic(9);
        end

        wait_drained();
        $display("Sent %0d UTF-8 bytes in little-endian, big-endian, passthrough and reserved modes.",
                 transcoder_sb.bytes_in);
        $display("Checked %0d output bytes, %0d surrogate pairs, %0d invalid leads dropped.",
                 transcoder_sb.bytes_out, transcoder_sb.pairs, transcoder_sb.dropped);
        if (transcoder_sb.errors == 0 && transcoder_sb.pending() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
